// ===== src/fsmc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsmc_pkg: shared types and ALU functions of the Forth stack machine core
//
// Holds the opcode and error codes, the controller states, the command and
// status bundles between controller and datapath, and the ALU functions.
// ----------------------------------------------------------------------------
package fsmc_pkg;

   typedef enum logic [5:0] {
      OP_LIT      = 6'd0,
      OP_DROP     = 6'd1,
      OP_TWO_DROP = 6'd2,
      OP_DUP      = 6'd3,
      OP_TWO_DUP  = 6'd4,
      OP_OVER     = 6'd5,
      OP_NIP      = 6'd6,
      OP_SWAP     = 6'd7,
      OP_PICK     = 6'd8,
      OP_RPICK    = 6'd9,
      OP_ROT      = 6'd10,
      OP_NROT     = 6'd11,
      OP_ADD      = 6'd12,
      OP_SUB      = 6'd13,
      OP_MUL      = 6'd14,
      OP_DIV      = 6'd15,
      OP_AND      = 6'd16,
      OP_OR       = 6'd17,
      OP_XOR      = 6'd18,
      OP_EQ       = 6'd19,
      OP_NE       = 6'd20,
      OP_LT       = 6'd21,
      OP_GT       = 6'd22,
      OP_GE       = 6'd23,
      OP_LE       = 6'd24,
      OP_INC      = 6'd25,
      OP_DEC      = 6'd26,
      OP_ZEQ      = 6'd27,
      OP_ZNE      = 6'd28,
      OP_ZLT      = 6'd29,
      OP_ZGT      = 6'd30,
      OP_INVERT   = 6'd31,
      OP_HALF     = 6'd32,
      OP_TWICE    = 6'd33,
      OP_LSHIFT   = 6'd34,
      OP_RSHIFT   = 6'd35,
      OP_STORE    = 6'd36,
      OP_FETCH    = 6'd37,
      OP_PSTORE   = 6'd38,
      OP_TOR      = 6'd39,
      OP_RFROM    = 6'd40,
      OP_RFETCH   = 6'd41,
      OP_RDROP    = 6'd42
   } op_type;

   typedef enum logic [2:0] {
      ERR_OK     = 3'd0,
      ERR_DUNDER = 3'd1,
      ERR_DOVER  = 3'd2,
      ERR_RUNDER = 3'd3,
      ERR_ROVER  = 3'd4,
      ERR_DIVZ   = 3'd5,
      ERR_ADDR   = 3'd6
   } err_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_ISTART,
      ST_ITER,
      ST_WRITE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic read;
      logic iter_start;
      logic iter_step;
      logic write;
      logic finish;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic err_found;
      logic iterate;
      logic iter_done;
      logic clear_done;
      logic rsp_free;
   } stat_type;

   localparam int WORD_W = 64;
   localparam int ITER_W = 7;
   localparam logic [ITER_W-1:0] ITER_STEPS = 7'd64;

   function automatic logic [WORD_W-1:0] alu_binop(logic [5:0] op, logic [WORD_W-1:0] a,
                                                   logic [WORD_W-1:0] b);
      logic wide;
      logic [WORD_W-1:0] res;
      wide = |b[WORD_W-1:6];
      unique case (op)
         OP_ADD:    res = a + b;
         OP_SUB:    res = a - b;
         OP_AND:    res = a & b;
         OP_OR:     res = a | b;
         OP_XOR:    res = a ^ b;
         OP_EQ:     res = {63'd0, a == b};
         OP_NE:     res = {63'd0, a != b};
         OP_LT:     res = {63'd0, $signed(a) < $signed(b)};
         OP_GT:     res = {63'd0, $signed(b) < $signed(a)};
         OP_GE:     res = {63'd0, !($signed(a) < $signed(b))};
         OP_LE:     res = {63'd0, !($signed(b) < $signed(a))};
         OP_LSHIFT: res = wide ? '0 : (a << b[5:0]);
         default:   res = wide ? {WORD_W{a[WORD_W-1]}} : WORD_W'($signed(a) >>> b[5:0]);
      endcase
      return res;
   endfunction

   function automatic logic [WORD_W-1:0] alu_unop(logic [5:0] op, logic [WORD_W-1:0] t);
      logic [WORD_W-1:0] res;
      unique case (op)
         OP_INC:    res = t + 64'd1;
         OP_DEC:    res = t - 64'd1;
         OP_ZEQ:    res = {63'd0, t == '0};
         OP_ZNE:    res = {63'd0, t != '0};
         OP_ZLT:    res = {63'd0, t[WORD_W-1]};
         OP_ZGT:    res = {63'd0, (t != '0) && !t[WORD_W-1]};
         OP_INVERT: res = ~t;
         OP_HALF:   res = {t[WORD_W-1], t[WORD_W-1:1]};
         default:   res = {t[WORD_W-2:0], 1'b0};
      endcase
      return res;
   endfunction

endpackage

// ===== src/fsmc_if.sv =====
// ----------------------------------------------------------------------------
// fsmc_if: item channels of the Forth stack machine core
//
// Request channel (opcode, literal) and result channel (top value, depths,
// error), each a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fsmc_req_if;
   logic               valid;
   logic               ready;
   logic [5:0]         opcode;
   logic signed [63:0] literal;

   modport source (output valid, output opcode, output literal, input ready);
   modport sink (input valid, input opcode, input literal, output ready);
endinterface

interface fsmc_rsp_if #(
   parameter int DCW = 9,
   parameter int RCW = 9
);
   logic               valid;
   logic               ready;
   logic signed [63:0] top_value;
   logic [DCW-1:0]     data_depth;
   logic [RCW-1:0]     return_depth;
   logic [2:0]         error;

   modport source (output valid, output top_value, output data_depth, output return_depth,
                   output error, input ready);
   modport sink (input valid, input top_value, input data_depth, input return_depth,
                 input error, output ready);
endinterface

// ===== src/fsmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsmc_ctrl: sequencer of the Forth stack machine core
//
// Steps each item through read, optional multiply/divide iterations, write
// and finish; sweeps the data memory clear after reset.
// ----------------------------------------------------------------------------
module fsmc_ctrl import fsmc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (stat.clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_READ;
         ST_READ: begin
            priority if (stat.err_found) state_in = ST_FINISH;
            else if (stat.iterate) state_in = ST_ISTART;
            else state_in = ST_WRITE;
         end
         ST_ISTART: state_in = ST_ITER;
         ST_ITER:   if (stat.iter_done) state_in = ST_WRITE;
         ST_WRITE:  state_in = ST_FINISH;
         ST_FINISH: if (stat.rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.accept     = (state_ff == ST_IDLE) && req_valid;
      cmd.read       = (state_ff == ST_READ);
      cmd.iter_start = (state_ff == ST_ISTART);
      cmd.iter_step  = (state_ff == ST_ITER) && !stat.iter_done;
      cmd.write      = (state_ff == ST_WRITE);
      cmd.finish     = (state_ff == ST_FINISH) && stat.rsp_free;
      cmd.clear_step = (state_ff == ST_CLEAR);
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// ===== src/fsmc_dpath.sv =====
// ----------------------------------------------------------------------------
// fsmc_dpath: datapath of the Forth stack machine core
//
// Top register, stack counts, data and return stack memories, data memory,
// fault checks, shift-add multiplier and restoring divider, result register.
// ----------------------------------------------------------------------------
module fsmc_dpath import fsmc_pkg::*; #(
   parameter int DATA_STACK_DEPTH   = 256,
   parameter int RETURN_STACK_DEPTH = 256,
   parameter int MEMORY_WORDS       = 1024,
   parameter int DCW                = 9,
   parameter int RCW                = 9
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [5:0]         opcode,
   input  logic [63:0]        literal,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [63:0]        rsp_top,
   output logic [DCW-1:0]     rsp_dcount,
   output logic [RCW-1:0]     rsp_rcount,
   output logic [2:0]         rsp_error
);

   localparam int DAW = $clog2(DATA_STACK_DEPTH);
   localparam int RAW = $clog2(RETURN_STACK_DEPTH);
   localparam int MAW = $clog2(MEMORY_WORDS);

   logic [63:0] dstk_mem [DATA_STACK_DEPTH];
   logic [63:0] rstk_mem [RETURN_STACK_DEPTH];
   logic [63:0] dmem_mem [MEMORY_WORDS];

   logic [5:0]        op_ff;
   logic [63:0]       lit_ff;
   logic [63:0]       top_ff;
   logic [DCW-1:0]    dc_ff;
   logic [RCW-1:0]    rc_ff;
   err_type           err_ff;
   logic [63:0]       a_ff, b_ff, r_ff, m_ff;
   logic [63:0]       acc_ff, opa_ff, opb_ff;
   logic              neg_ff;
   logic [ITER_W-1:0] cnt_ff;
   logic [MAW-1:0]    clr_ff;
   logic              rsp_valid_ff;
   logic [63:0]       rsp_top_ff;
   logic [DCW-1:0]    rsp_dc_ff;
   logic [RCW-1:0]    rsp_rc_ff;
   logic [2:0]        rsp_err_ff;

   err_type        err_in;
   logic [DCW-1:0] dm1, dm2, dp1, dpick, dc_in;
   logic [RCW-1:0] rm1, rpick, rc_in;
   logic [DAW-1:0] rd_a_addr;
   logic [RAW-1:0] rd_r_addr;
   logic           ge1, ge2, room, room2, rge1, rroom, t_ge_c, t_ge_rc, bad_addr;
   logic           is_binop;
   logic           dw_en, rw_en, mw_en;
   logic [DAW-1:0] dw_addr;
   logic [63:0]    dw_data, mw_data, top_in, quo;
   logic [MAW-1:0] mw_addr;
   logic [64:0]    trial;
   logic           ok;

   assign dm1   = dc_ff - DCW'(1);
   assign dm2   = dc_ff - DCW'(2);
   assign dp1   = dc_ff + DCW'(1);
   assign dpick = dm1 - top_ff[DCW-1:0];
   assign rm1   = rc_ff - RCW'(1);
   assign rpick = rm1 - top_ff[RCW-1:0];

   assign ge1      = (dc_ff != '0);
   assign ge2      = (dc_ff >= DCW'(2));
   assign room     = (dc_ff < DCW'(DATA_STACK_DEPTH));
   assign room2    = (dc_ff <= DCW'(DATA_STACK_DEPTH - 2));
   assign rge1     = (rc_ff != '0);
   assign rroom    = (rc_ff < RCW'(RETURN_STACK_DEPTH));
   assign t_ge_c   = (top_ff >= 64'(dc_ff));
   assign t_ge_rc  = (top_ff >= 64'(rc_ff));
   assign bad_addr = (top_ff >= 64'(MEMORY_WORDS));
   assign is_binop = ((op_ff >= OP_ADD) && (op_ff <= OP_LE)) || (op_ff == OP_LSHIFT)
                     || (op_ff == OP_RSHIFT);

   always_comb begin
      err_in = ERR_OK;
      unique case (op_ff)
         OP_LIT, OP_DUP: if (!room) err_in = ERR_DOVER;
         OP_DROP, OP_NIP, OP_SWAP: if (!ge1) err_in = ERR_DUNDER;
         OP_TWO_DROP, OP_ROT, OP_NROT: if (!ge2) err_in = ERR_DUNDER;
         OP_TWO_DUP: begin
            priority if (!ge1) err_in = ERR_DUNDER;
            else if (!room2) err_in = ERR_DOVER;
         end
         OP_OVER: begin
            priority if (!ge1) err_in = ERR_DUNDER;
            else if (!room) err_in = ERR_DOVER;
         end
         OP_PICK:  if (t_ge_c) err_in = ERR_DUNDER;
         OP_RPICK: if (t_ge_rc) err_in = ERR_RUNDER;
         OP_STORE, OP_PSTORE: begin
            priority if (!ge2) err_in = ERR_DUNDER;
            else if (bad_addr) err_in = ERR_ADDR;
         end
         OP_FETCH: if (bad_addr) err_in = ERR_ADDR;
         OP_TOR: begin
            priority if (!ge1) err_in = ERR_DUNDER;
            else if (!rroom) err_in = ERR_ROVER;
         end
         OP_RFROM, OP_RFETCH: begin
            priority if (!room) err_in = ERR_DOVER;
            else if (!rge1) err_in = ERR_RUNDER;
         end
         OP_RDROP: if (!rge1) err_in = ERR_RUNDER;
         default: begin
            if (is_binop) begin
               priority if (!ge1) err_in = ERR_DUNDER;
               else if ((op_ff == OP_DIV) && (top_ff == '0)) err_in = ERR_DIVZ;
            end
         end
      endcase
   end

   assign rd_a_addr = (op_ff == OP_PICK) ? dpick[DAW-1:0] : dm1[DAW-1:0];
   assign rd_r_addr = (op_ff == OP_RPICK) ? rpick[RAW-1:0] : rm1[RAW-1:0];
   assign ok        = (err_ff == ERR_OK);

   // data stack write port
   always_comb begin
      dw_en   = 1'b0;
      dw_addr = dc_ff[DAW-1:0];
      dw_data = top_ff;
      if (cmd.write) begin
         unique case (op_ff)
            OP_LIT, OP_DUP, OP_TWO_DUP, OP_OVER, OP_RFROM, OP_RFETCH: dw_en = 1'b1;
            OP_SWAP: begin
               dw_en   = 1'b1;
               dw_addr = dm1[DAW-1:0];
            end
            OP_ROT: begin
               dw_en   = 1'b1;
               dw_addr = dm2[DAW-1:0];
               dw_data = a_ff;
            end
            OP_NROT: begin
               dw_en   = 1'b1;
               dw_addr = dm2[DAW-1:0];
            end
            default: dw_en = 1'b0;
         endcase
      end else if (cmd.finish && ok) begin
         unique case (op_ff)
            OP_TWO_DUP: begin
               dw_en   = 1'b1;
               dw_addr = dp1[DAW-1:0];
               dw_data = a_ff;
            end
            OP_ROT: begin
               dw_en   = 1'b1;
               dw_addr = dm1[DAW-1:0];
            end
            OP_NROT: begin
               dw_en   = 1'b1;
               dw_addr = dm1[DAW-1:0];
               dw_data = b_ff;
            end
            default: dw_en = 1'b0;
         endcase
      end
   end

   assign rw_en = cmd.write && (op_ff == OP_TOR);

   always_comb begin
      mw_en   = 1'b0;
      mw_addr = top_ff[MAW-1:0];
      mw_data = a_ff;
      priority if (cmd.clear_step) begin
         mw_en   = 1'b1;
         mw_addr = clr_ff;
         mw_data = '0;
      end else if (cmd.write && (op_ff == OP_STORE)) begin
         mw_en = 1'b1;
      end else if (cmd.write && (op_ff == OP_PSTORE)) begin
         mw_en   = 1'b1;
         mw_data = m_ff + a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (dw_en) dstk_mem[dw_addr] <= dw_data;
      if (cmd.read) begin
         a_ff <= dstk_mem[rd_a_addr];
         b_ff <= dstk_mem[dm2[DAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (rw_en) rstk_mem[rc_ff[RAW-1:0]] <= top_ff;
      if (cmd.read) r_ff <= rstk_mem[rd_r_addr];
   end

   always_ff @(posedge clock) begin
      if (mw_en) dmem_mem[mw_addr] <= mw_data;
      if (cmd.read) m_ff <= dmem_mem[top_ff[MAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + MAW'(1);
      end
   end

   // shift-add multiply, restoring divide on magnitudes
   assign trial = {acc_ff, opb_ff[63]} - {1'b0, opa_ff};
   assign quo   = neg_ff ? (64'd0 - opb_ff) : opb_ff;

   always_ff @(posedge clock) begin
      if (cmd.iter_start) begin
         acc_ff <= '0;
         cnt_ff <= ITER_STEPS;
         if (op_ff == OP_MUL) begin
            opa_ff <= a_ff;
            opb_ff <= top_ff;
            neg_ff <= 1'b0;
         end else begin
            opa_ff <= top_ff[63] ? (64'd0 - top_ff) : top_ff;
            opb_ff <= a_ff[63] ? (64'd0 - a_ff) : a_ff;
            neg_ff <= a_ff[63] ^ top_ff[63];
         end
      end else if (cmd.iter_step) begin
         cnt_ff <= cnt_ff - ITER_W'(1);
         if (op_ff == OP_MUL) begin
            if (opb_ff[0]) acc_ff <= acc_ff + opa_ff;
            opa_ff <= {opa_ff[62:0], 1'b0};
            opb_ff <= {1'b0, opb_ff[63:1]};
         end else if (!trial[64]) begin
            acc_ff <= trial[63:0];
            opb_ff <= {opb_ff[62:0], 1'b1};
         end else begin
            acc_ff <= {acc_ff[62:0], opb_ff[63]};
            opb_ff <= {opb_ff[62:0], 1'b0};
         end
      end
   end

   always_comb begin
      top_in = top_ff;
      dc_in  = dc_ff;
      rc_in  = rc_ff;
      unique case (op_ff)
         OP_LIT: begin
            top_in = lit_ff;
            dc_in  = dp1;
         end
         OP_DROP: begin
            top_in = a_ff;
            dc_in  = dm1;
         end
         OP_TWO_DROP, OP_STORE, OP_PSTORE: begin
            top_in = b_ff;
            dc_in  = dm2;
         end
         OP_DUP:     dc_in = dp1;
         OP_TWO_DUP: dc_in = dc_ff + DCW'(2);
         OP_OVER: begin
            top_in = a_ff;
            dc_in  = dp1;
         end
         OP_NIP:            dc_in  = dm1;
         OP_SWAP, OP_PICK:  top_in = a_ff;
         OP_RPICK:          top_in = r_ff;
         OP_ROT:            top_in = b_ff;
         OP_NROT:           top_in = a_ff;
         OP_MUL: begin
            top_in = acc_ff;
            dc_in  = dm1;
         end
         OP_DIV: begin
            top_in = quo;
            dc_in  = dm1;
         end
         OP_FETCH: top_in = m_ff;
         OP_TOR: begin
            top_in = a_ff;
            dc_in  = dm1;
            rc_in  = rc_ff + RCW'(1);
         end
         OP_RFROM: begin
            top_in = r_ff;
            dc_in  = dp1;
            rc_in  = rm1;
         end
         OP_RFETCH: begin
            top_in = r_ff;
            dc_in  = dp1;
         end
         OP_RDROP: rc_in = rm1;
         default: begin
            priority if (is_binop) begin
               top_in = alu_binop(op_ff, a_ff, top_ff);
               dc_in  = dm1;
            end else if ((op_ff >= OP_INC) && (op_ff <= OP_TWICE)) begin
               top_in = alu_unop(op_ff, top_ff);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= opcode;
         lit_ff <= literal;
      end
      if (cmd.read) err_ff <= err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
         dc_ff  <= '0;
         rc_ff  <= '0;
      end else if (cmd.finish && ok) begin
         top_ff <= top_in;
         dc_ff  <= dc_in;
         rc_ff  <= rc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_top_ff <= ok ? top_in : top_ff;
         rsp_dc_ff  <= ok ? dc_in : dc_ff;
         rsp_rc_ff  <= ok ? rc_in : rc_ff;
         rsp_err_ff <= err_ff;
      end
   end

   assign stat.err_found  = (err_in != ERR_OK);
   assign stat.iterate    = (op_ff == OP_MUL) || (op_ff == OP_DIV);
   assign stat.iter_done  = (cnt_ff == '0);
   assign stat.clear_done = (clr_ff == MAW'(MEMORY_WORDS - 1));
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_top    = rsp_top_ff;
   assign rsp_dcount = rsp_dc_ff;
   assign rsp_rcount = rsp_rc_ff;
   assign rsp_error  = rsp_err_ff;

endmodule

// ===== src/forth_stack_machine_core.sv =====
// ----------------------------------------------------------------------------
// forth_stack_machine_core: Forth dual-stack machine core
//
// Executes one Forth primitive per request item on a 64-bit data stack,
// a return stack and a word-addressed data memory; returns one result item.
// ----------------------------------------------------------------------------
// After reset the core sweeps the data memory to zero, one word a cycle, and
// accepts no item until the sweep is done. An item then passes through the
// read, write and finish steps before the next one can be taken (the stack
// memories are single-write); a fault skips the write step. Multiply and
// divide add a start step and the one-bit-per-cycle shift-add or restoring
// divide loop. The result sits in an output register, so the next item is
// accepted while a result still waits; finishing stalls only while that
// register is full and not being taken.
module forth_stack_machine_core import fsmc_pkg::*; #(
   parameter int DATA_STACK_DEPTH   = 256,
   parameter int RETURN_STACK_DEPTH = 256,
   parameter int MEMORY_WORDS       = 1024
) (
   input logic        clock,
   input logic        reset,
   fsmc_req_if.sink   req_bus,
   fsmc_rsp_if.source rsp_bus
);

   localparam int DCW = $clog2(DATA_STACK_DEPTH + 1);
   localparam int RCW = $clog2(RETURN_STACK_DEPTH + 1);

   cmd_type        cmd;
   stat_type       stat;
   logic [63:0]    rsp_top;
   logic [DCW-1:0] rsp_dcount;
   logic [RCW-1:0] rsp_rcount;

   fsmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fsmc_dpath #(
      .DATA_STACK_DEPTH   (DATA_STACK_DEPTH),
      .RETURN_STACK_DEPTH (RETURN_STACK_DEPTH),
      .MEMORY_WORDS       (MEMORY_WORDS),
      .DCW                (DCW),
      .RCW                (RCW)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .opcode     (req_bus.opcode),
      .literal    (req_bus.literal),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_top    (rsp_top),
      .rsp_dcount (rsp_dcount),
      .rsp_rcount (rsp_rcount),
      .rsp_error  (rsp_bus.error)
   );

   assign rsp_bus.top_value    = rsp_top;
   assign rsp_bus.data_depth   = rsp_dcount;
   assign rsp_bus.return_depth = rsp_rcount;

endmodule

// ===== src/fsmc_checker.sv =====
// ----------------------------------------------------------------------------
// fsmc_checker: port-level checks of the Forth stack machine core
//
// Watches the request and result channels and the reported depths.
// ----------------------------------------------------------------------------
module fsmc_checker import fsmc_pkg::*; #(
   parameter int DATA_STACK_DEPTH   = 256,
   parameter int RETURN_STACK_DEPTH = 256,
   parameter int DCW                = 9,
   parameter int RCW                = 9
) (
   input logic           clock,
   input logic           reset,
   input logic           req_valid,
   input logic           req_ready,
   input logic           rsp_valid,
   input logic           rsp_ready,
   input logic [DCW-1:0] data_depth,
   input logic [RCW-1:0] return_depth,
   input logic [2:0]     error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped before taken");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in work");

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (data_depth <= DCW'(DATA_STACK_DEPTH))
                    && (return_depth <= RCW'(RETURN_STACK_DEPTH)))
      else $error("reported depth beyond stack size");

   a_dover_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (error == ERR_DOVER) |-> (data_depth >= DCW'(DATA_STACK_DEPTH - 1)))
      else $error("data overflow with room left");

   a_rover_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (error == ERR_ROVER) |-> (return_depth == RCW'(RETURN_STACK_DEPTH)))
      else $error("return overflow with room left");

endmodule

bind forth_stack_machine_core fsmc_checker #(
   .DATA_STACK_DEPTH   (DATA_STACK_DEPTH),
   .RETURN_STACK_DEPTH (RETURN_STACK_DEPTH),
   .DCW                ($clog2(DATA_STACK_DEPTH + 1)),
   .RCW                ($clog2(RETURN_STACK_DEPTH + 1))
) u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .data_depth   (rsp_bus.data_depth),
   .return_depth (rsp_bus.return_depth),
   .error        (rsp_bus.error)
);

// ===== dv/fsmc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsmc_scoreboard: result predictor and scoreboard for the Forth core
//
// Watches both channels, runs each accepted item through a behavioral model
// of the stacks and memory, and compares every result item field by field.
// ----------------------------------------------------------------------------
module fsmc_scoreboard import fsmc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [5:0]           req_opcode,
   input  logic [63:0]          req_literal,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [63:0]          rsp_top_value,
   input  logic [8:0]           rsp_data_depth,
   input  logic [8:0]           rsp_return_depth,
   input  logic [2:0]           rsp_error,
   output int                   fail_count,
   output int                   pending
);
   localparam int DDEPTH = 256;
   localparam int RDEPTH = 256;
   localparam int MWORDS = 1024;

   typedef struct packed {
      logic [63:0] top;
      logic [8:0]  ddepth;
      logic [8:0]  rdepth;
      logic [2:0]  err;
   } outcome_t;

   logic [63:0] m_top;
   logic [63:0] m_dstk [DDEPTH];
   logic [63:0] m_rstk [RDEPTH];
   logic [63:0] m_mem [MWORDS];
   int unsigned m_dc, m_rc;
   outcome_t    awaited [$];

   function automatic logic [63:0] sra64(logic [63:0] x, logic [63:0] n);
      if (n >= 64) return {64{x[63]}};
      return $signed(x) >>> n[5:0];
   endfunction

   function automatic logic [63:0] quot(logic [63:0] a, logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q = ma / mb;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   function automatic logic [63:0] two_op(logic [5:0] op, logic [63:0] a, logic [63:0] b);
      case (op)
         OP_ADD:    return a + b;
         OP_SUB:    return a - b;
         OP_MUL:    return a * b;
         OP_DIV:    return quot(a, b);
         OP_AND:    return a & b;
         OP_OR:     return a | b;
         OP_XOR:    return a ^ b;
         OP_EQ:     return 64'(a == b);
         OP_NE:     return 64'(a != b);
         OP_LT:     return 64'($signed(a) < $signed(b));
         OP_GT:     return 64'($signed(b) < $signed(a));
         OP_GE:     return 64'(!($signed(a) < $signed(b)));
         OP_LE:     return 64'(!($signed(b) < $signed(a)));
         OP_LSHIFT: return (b >= 64) ? 64'd0 : a << b[5:0];
         default:   return sra64(a, b);
      endcase
   endfunction

   function automatic logic [63:0] one_op(logic [5:0] op, logic [63:0] t);
      case (op)
         OP_INC:    return t + 1;
         OP_DEC:    return t - 1;
         OP_ZEQ:    return 64'(t == 0);
         OP_ZNE:    return 64'(t != 0);
         OP_ZLT:    return 64'(t[63]);
         OP_ZGT:    return 64'(t != 0 && !t[63]);
         OP_INVERT: return ~t;
         OP_HALF:   return sra64(t, 1);
         default:   return t << 1;
      endcase
   endfunction

   task automatic execute_item(input logic [5:0] op, input logic [63:0] lit,
                               output logic [2:0] err);
      int unsigned c, rc;
      logic [63:0] t, x;
      c = m_dc;
      rc = m_rc;
      t = m_top;
      err = ERR_OK;
      case (op)
         OP_LIT, OP_DUP: begin
            if (c >= DDEPTH) err = ERR_DOVER;
            else begin
               m_dstk[c] = t; m_dc = c + 1;
               if (op == OP_LIT) m_top = lit;
            end
         end
         OP_DROP: if (c < 1) err = ERR_DUNDER; else begin m_dc = c - 1; m_top = m_dstk[c-1]; end
         OP_TWO_DROP: if (c < 2) err = ERR_DUNDER; else begin m_dc = c - 2; m_top = m_dstk[c-2]; end
         OP_TWO_DUP: begin
            if (c < 1) err = ERR_DUNDER;
            else if (DDEPTH - c < 2) err = ERR_DOVER;
            else begin m_dstk[c] = t; m_dstk[c+1] = m_dstk[c-1]; m_dc = c + 2; end
         end
         OP_OVER: begin
            if (c < 1) err = ERR_DUNDER;
            else if (c >= DDEPTH) err = ERR_DOVER;
            else begin x = m_dstk[c-1]; m_dstk[c] = t; m_dc = c + 1; m_top = x; end
         end
         OP_NIP: if (c < 1) err = ERR_DUNDER; else m_dc = c - 1;
         OP_SWAP: if (c < 1) err = ERR_DUNDER; else begin m_top = m_dstk[c-1]; m_dstk[c-1] = t; end
         OP_PICK: if (t >= c) err = ERR_DUNDER; else m_top = m_dstk[c-1-t];
         OP_RPICK: if (t >= rc) err = ERR_RUNDER; else m_top = m_rstk[rc-1-t];
         OP_ROT: begin
            if (c < 2) err = ERR_DUNDER;
            else begin
               x = m_dstk[c-2]; m_dstk[c-2] = m_dstk[c-1]; m_dstk[c-1] = t; m_top = x;
            end
         end
         OP_NROT: begin
            if (c < 2) err = ERR_DUNDER;
            else begin
               x = m_dstk[c-2]; m_dstk[c-2] = t; m_top = m_dstk[c-1]; m_dstk[c-1] = x;
            end
         end
         OP_STORE, OP_PSTORE: begin
            if (c < 2) err = ERR_DUNDER;
            else if (t >= MWORDS) err = ERR_ADDR;
            else begin
               if (op == OP_STORE) m_mem[t] = m_dstk[c-1];
               else m_mem[t] = m_mem[t] + m_dstk[c-1];
               m_dc = c - 2; m_top = m_dstk[c-2];
            end
         end
         OP_FETCH: if (t >= MWORDS) err = ERR_ADDR; else m_top = m_mem[t];
         OP_TOR: begin
            if (c < 1) err = ERR_DUNDER;
            else if (rc >= RDEPTH) err = ERR_ROVER;
            else begin
               m_rstk[rc] = t; m_rc = rc + 1; m_dc = c - 1; m_top = m_dstk[c-1];
            end
         end
         OP_RFROM, OP_RFETCH: begin
            if (c >= DDEPTH) err = ERR_DOVER;
            else if (rc < 1) err = ERR_RUNDER;
            else begin
               x = m_rstk[rc-1];
               if (op == OP_RFROM) m_rc = rc - 1;
               m_dstk[c] = t; m_dc = c + 1; m_top = x;
            end
         end
         OP_RDROP: if (rc < 1) err = ERR_RUNDER; else m_rc = rc - 1;
         default: begin
            if ((op >= OP_ADD && op <= OP_LE) || op == OP_LSHIFT || op == OP_RSHIFT) begin
               if (c < 1) err = ERR_DUNDER;
               else if (op == OP_DIV && t == 0) err = ERR_DIVZ;
               else begin m_top = two_op(op, m_dstk[c-1], t); m_dc = c - 1; end
            end else if (op >= OP_INC && op <= OP_TWICE) begin
               m_top = one_op(op, t);
            end
         end
      endcase
   endtask

   assign pending = awaited.size();

   always @(posedge clock) begin
      logic [2:0] e;
      outcome_t want, got;
      if (reset) begin
         m_top = '0;
         m_dc = 0;
         m_rc = 0;
         for (int i = 0; i < MWORDS; i++) m_mem[i] = '0;
         awaited.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_top_value, rsp_data_depth, rsp_return_depth, rsp_error};
            if (awaited.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected result item %h", got);
            end else begin
               want = awaited.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: top %h/%h dd %0d/%0d rd %0d/%0d err %0d/%0d",
                              want.top, got.top, want.ddepth, got.ddepth,
                              want.rdepth, got.rdepth, want.err, got.err);
               end
            end
         end
         if (req_valid && req_ready) begin
            execute_item(req_opcode, req_literal, e);
            awaited.push_back('{m_top, 9'(m_dc), 9'(m_rc), e});
         end
      end
   end
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the Forth stack machine core
//
// Drives directed and random primitive sequences with random gaps and a
// long result stall; the checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb;
   import fsmc_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic hold_off = 0;
   int   fail_count, pending;
   bit   done = 0;

   fsmc_req_if req_ch();
   fsmc_rsp_if rsp_ch();

   forth_stack_machine_core uut (
      .clock(clock), .reset(reset), .req_bus(req_ch.sink), .rsp_bus(rsp_ch.source));

   fsmc_scoreboard chk (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .req_opcode(req_ch.opcode), .req_literal(req_ch.literal),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_top_value(rsp_ch.top_value), .rsp_data_depth(rsp_ch.data_depth),
      .rsp_return_depth(rsp_ch.return_depth), .rsp_error(rsp_ch.error),
      .fail_count(fail_count), .pending(pending));

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 0;
      req_ch.opcode = '0;
      req_ch.literal = '0;
      rsp_ch.ready = 0;
   end

   task automatic send_item(input logic [5:0] op, input logic [63:0] lit);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.opcode <= op;
      req_ch.literal <= lit;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 6))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7fff_ffff_ffff_ffff;
         2: return '1;
         3: return $urandom_range(0, 70);
         4: return $urandom_range(0, 1100);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic push_lit(input logic [63:0] v);
      send_item(OP_LIT, v);
   endtask

   initial begin
      int mode;
      repeat (12) @(posedge clock);
      reset <= 0;
      // underflow on empty stacks, then directed corner cases
      send_item(OP_DROP, 0);
      send_item(OP_RDROP, 0);
      send_item(OP_RFROM, 0);
      send_item(OP_ADD, 0);
      send_item(OP_FETCH, 0);
      send_item(6'd50, '1);
      push_lit(64'h8000_0000_0000_0000);
      push_lit('1);
      send_item(OP_TWO_DUP, 0);
      send_item(OP_DIV, 0);
      push_lit(0);
      send_item(OP_DIV, 0);
      push_lit(70);
      send_item(OP_RSHIFT, 0);
      push_lit(64'h7fff_ffff_ffff_ffff);
      push_lit(5);
      send_item(OP_STORE, 0);
      push_lit(5);
      send_item(OP_FETCH, 0);
      push_lit(2000);
      send_item(OP_FETCH, 0);
      send_item(OP_PICK, 0);
      send_item(OP_TOR, 0);
      send_item(OP_RPICK, 0);
      // fill the data stack to overflow, then drain it onto the return stack to overflow
      repeat (260) send_item(OP_DUP, 0);
      send_item(OP_TWO_DUP, 0);
      send_item(OP_LIT, 1);
      repeat (200) send_item(OP_TOR, 0);
      repeat (70) send_item(OP_TOR, 0);
      repeat (100) send_item(OP_RFROM, 0);
      repeat (300) begin
         mode = $urandom_range(0, 9);
         if (mode < 3) push_lit(pick_value());
         else send_item(6'($urandom_range(0, 63)), pick_value());
         if ($urandom_range(0, 4) == 0) send_item(OP_TWO_DROP, 0);
      end
      repeat (300) begin
         mode = $urandom_range(0, 4);
         if (mode == 0) begin
            push_lit(pick_value());
            push_lit($urandom_range(0, 1023));
            send_item($urandom_range(0, 1) ? OP_STORE : OP_PSTORE, 0);
         end else if (mode == 1) begin
            push_lit($urandom_range(0, 1030));
            send_item(OP_FETCH, 0);
         end else begin
            push_lit(pick_value());
            send_item(6'($urandom_range(0, 45)), pick_value());
         end
      end
      req_ch.valid <= 0;
      done = 1;
   end

   initial begin
      rsp_ch.ready <= 0;
      @(negedge reset);
      repeat (1100) @(posedge clock);
      forever begin
         int wait_n;
         wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if (hold_off) begin
            rsp_ch.ready <= 0;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         if (wait_n > 0) begin
            rsp_ch.ready <= 0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_ch.ready <= 1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      @(negedge reset);
      repeat (3000) @(posedge clock);
      hold_off = 1;
   end

   initial begin
      wait (done);
      wait (pending == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #8ms;
      $display("Some tests failed");
      $finish;
   end
endmodule
